/* rtl/snco_pkg.sv */
// Shared types, constants and tables for the FM-scaled sine oscillator.
`default_nettype none

package snco_pkg;

    // Default sizes handed to the top-level parameters
    localparam int PHASE_BITS_DEF       = 32;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Field and register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MOD_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 18;
    localparam int TAB_W      = 15;

    // Register reset values
    localparam logic [31:0]       SCALE_RST  = 32'h0001_0000;
    localparam logic [31:0]       OFFSET_RST = 32'h0000_0000;
    localparam logic [RATE_W-1:0] RATE_RST   = 18'd48000;

    // Table build rotator
    localparam int                CORDIC_ITERS = 30;
    localparam int                IT_W         = $clog2(CORDIC_ITERS);
    localparam int                CW_XY        = 33;
    localparam logic signed [CW_XY-1:0] CORDIC_GAIN = 33'sd652032874;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_SCALE  = 2'd0,
        REG_FREQ_OFFSET = 2'd1,
        REG_SAMPLE_RATE = 2'd2
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_BUILD_INIT,
        S_BUILD_ITER,
        S_BUILD_WR,
        S_IDLE,
        S_MUL,
        S_FREQ,
        S_DINIT,
        S_DIV,
        S_PHASE,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic build_init;
        logic cordic_step;
        logic build_write;
        logic accept;
        logic mul;
        logic freq;
        logic div_init;
        logic div_step;
        logic phase_upd;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic cordic_last;
        logic build_last;
        logic build_done;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [IT_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/sine_nco_with_fm_scaling.sv */
// Top level of the FM-scaled sine oscillator: sequencer plus datapath.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_mod_value  (s32, Q16.16)
//  output    out        o_valid / i_ready   o_sample     (s16, Q1.15)
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data (no wait)
//
// Each item runs through the multiply, frequency, divider setup, divide, phase and emit
// states, the divide being the radix-4 restoring divider for the phase step; a new item is
// accepted only in the idle state, once the previous one has left the emit state.
// After reset the quarter-wave table (SINE_TABLE_DEPTH+1 entries) is built by an
// iterative rotator, and no item is accepted meanwhile.
// A result waits in the output register; the next item is taken while it waits
// and is held at its end until that register frees up.
`default_nettype none

module sine_nco_with_fm_scaling #(
    parameter int PHASE_BITS       = snco_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = snco_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [snco_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [snco_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  signed [snco_pkg::MOD_W-1:0]    i_mod_value,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [snco_pkg::SAMPLE_W-1:0] o_sample
);

    snco_pkg::t_dp_cmd w_cmd;
    snco_pkg::t_dp_sts w_sts;

    snco_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    snco_dp #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mod_value (i_mod_value),
        .i_ready     (i_ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_sample    (o_sample)
    );

endmodule

`default_nettype wire

/* rtl/snco_ctrl.sv */
// Sequencer for the oscillator: table build after reset, then one item at a time.
`default_nettype none

module snco_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  snco_pkg::t_dp_sts   i_sts,
    output logic                o_ready,
    output snco_pkg::t_dp_cmd   o_cmd
);

    snco_pkg::t_state r_state;
    snco_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snco_pkg::S_BUILD_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            snco_pkg::S_BUILD_INIT: n_state = snco_pkg::S_BUILD_ITER;
            snco_pkg::S_BUILD_ITER: begin
                if (i_sts.cordic_last) n_state = snco_pkg::S_BUILD_WR;
            end
            snco_pkg::S_BUILD_WR: begin
                n_state = i_sts.build_last ? snco_pkg::S_IDLE : snco_pkg::S_BUILD_INIT;
            end
            snco_pkg::S_IDLE: begin
                if (i_valid) n_state = snco_pkg::S_MUL;
            end
            snco_pkg::S_MUL:   n_state = snco_pkg::S_FREQ;
            snco_pkg::S_FREQ:  n_state = snco_pkg::S_DINIT;
            snco_pkg::S_DINIT: n_state = snco_pkg::S_DIV;
            snco_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = snco_pkg::S_PHASE;
            end
            snco_pkg::S_PHASE: n_state = snco_pkg::S_EMIT;
            snco_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = snco_pkg::S_IDLE;
            end
            default: n_state = snco_pkg::S_BUILD_INIT;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            snco_pkg::S_BUILD_INIT: o_cmd.build_init  = 1'b1;
            snco_pkg::S_BUILD_ITER: o_cmd.cordic_step = 1'b1;
            snco_pkg::S_BUILD_WR:   o_cmd.build_write = 1'b1;
            snco_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            snco_pkg::S_MUL:   o_cmd.mul       = 1'b1;
            snco_pkg::S_FREQ:  o_cmd.freq      = 1'b1;
            snco_pkg::S_DINIT: o_cmd.div_init  = 1'b1;
            snco_pkg::S_DIV:   o_cmd.div_step  = 1'b1;
            snco_pkg::S_PHASE: o_cmd.phase_upd = 1'b1;
            snco_pkg::S_EMIT:  o_cmd.emit      = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    // Items are only taken once the sine table is complete
    a_idle_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == snco_pkg::S_IDLE) |-> i_sts.build_done)
        else $error("idle before sine table built");

endmodule

`default_nettype wire

/* rtl/snco_dp.sv */
// Datapath: config registers, sine table and its builder, frequency, divider, phase.
`default_nettype none

module snco_dp #(
    parameter int PHASE_BITS       = snco_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = snco_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [snco_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [snco_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire  signed [snco_pkg::MOD_W-1:0]    i_mod_value,
    input  wire                                  i_ready,
    input  snco_pkg::t_dp_cmd                    i_cmd,
    output snco_pkg::t_dp_sts                    o_sts,
    output logic                                 o_valid,
    output logic signed [snco_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int D      = SINE_TABLE_DEPTH;
    localparam int AW     = $clog2(D + 1);
    localparam int IW     = $clog2(4 * D);
    localparam int RMW    = $clog2(D) + 1;
    localparam int DW     = PHASE_BITS + 16;
    localparam int EW     = DW + (DW % 2);
    localparam int NSTEP  = EW / 2;
    localparam int CNTW   = $clog2(NSTEP);
    localparam int RW     = snco_pkg::RATE_W;
    localparam int XW     = snco_pkg::CW_XY;
    localparam logic [30:0]    ANG_Q = 31'((64'd1 << 30) / D);
    localparam logic [RMW-1:0] ANG_R = RMW'((64'd1 << 30) % D);
    localparam logic signed [48:0] F_MAX = 49'sd2147483647;
    localparam logic signed [48:0] F_MIN = -49'sd2147483648;

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_scale;
    logic signed [31:0] r_offset;
    logic [RW-1:0]      r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= snco_pkg::SCALE_RST;
            r_offset <= snco_pkg::OFFSET_RST;
            r_rate   <= snco_pkg::RATE_RST;
        end else if (i_cfg_we) begin
            unique case (snco_pkg::t_cfg_reg'(i_cfg_idx))
                snco_pkg::REG_FREQ_SCALE:  r_scale  <= i_cfg_data;
                snco_pkg::REG_FREQ_OFFSET: r_offset <= i_cfg_data;
                snco_pkg::REG_SAMPLE_RATE: r_rate   <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sine table builder ----------------
    logic [AW-1:0]          r_k;
    logic [30:0]            r_ang;
    logic [RMW-1:0]         r_ang_rem;
    logic                   r_built;
    logic [snco_pkg::IT_W-1:0] r_it;
    logic signed [XW-1:0]   r_x;
    logic signed [XW-1:0]   r_y;
    logic signed [XW-1:0]   r_z;
    logic signed [XW-1:0]   w_xs;
    logic signed [XW-1:0]   w_ys;
    logic signed [XW-1:0]   w_at;
    logic [RMW-1:0]         w_rem_sum;
    logic signed [48:0]     w_yr;
    logic signed [48:0]     w_yq;
    logic [snco_pkg::TAB_W-1:0] w_entry;

    assign w_xs = r_x >>> r_it;
    assign w_ys = r_y >>> r_it;
    assign w_at = XW'(signed'({1'b0, snco_pkg::atan_turn(r_it)}));
    assign w_rem_sum = r_ang_rem + ANG_R;

    // Round y to Q1.15 and clamp to the positive quarter-wave range
    assign w_yr = (49'(r_y) <<< 15) - 49'(r_y) + 49'sd536870912;
    assign w_yq = w_yr >>> 30;
    always_comb begin
        if (w_yr < 0) begin
            w_entry = '0;
        end else if (w_yq > 49'sd32767) begin
            w_entry = snco_pkg::TAB_W'(32767);
        end else begin
            w_entry = w_yq[snco_pkg::TAB_W-1:0];
        end
    end

    // Advance entry index and start angle floor(k * 2^30 / D)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_ang     <= '0;
            r_ang_rem <= '0;
            r_built   <= 1'b0;
        end else if (i_cmd.build_write) begin
            r_k <= r_k + AW'(1);
            if (w_rem_sum >= RMW'(D)) begin
                r_ang_rem <= w_rem_sum - RMW'(D);
                r_ang     <= r_ang + ANG_Q + 31'd1;
            end else begin
                r_ang_rem <= w_rem_sum;
                r_ang     <= r_ang + ANG_Q;
            end
            if (r_k == AW'(D)) r_built <= 1'b1;
        end
    end

    // Rotate one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_x  <= snco_pkg::CORDIC_GAIN;
            r_y  <= '0;
            r_z  <= XW'(signed'({1'b0, r_ang}));
            r_it <= '0;
        end else if (i_cmd.cordic_step) begin
            r_it <= r_it + snco_pkg::IT_W'(1);
            if (!r_z[XW-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    // ---------------- phase and sine lookup ----------------
    logic [PHASE_BITS-1:0]    r_phase;
    logic [PHASE_BITS+31:0]   w_pext;
    logic [31:0]              w_p32;
    logic [63:0]              w_idx_prod;
    logic [IW-1:0]            r_idx;
    logic                     w_ge2;
    logic                     w_ge1;
    logic [IW-1:0]            w_i1;
    logic [IW-1:0]            w_rr;
    logic [AW-1:0]            w_rd_addr;
    logic [snco_pkg::TAB_W-1:0] r_table [0:D];
    logic [snco_pkg::TAB_W-1:0] r_tab_q;
    logic                     r_sneg;
    logic signed [snco_pkg::SAMPLE_W-1:0] r_sample;

    assign w_pext     = {r_phase, 32'd0};
    assign w_p32      = w_pext[PHASE_BITS+31 -: 32];
    assign w_idx_prod = 64'(w_p32) * 64'(4 * D);

    // Split table index into quadrant and offset
    assign w_ge2     = r_idx >= IW'(2 * D);
    assign w_i1      = w_ge2 ? r_idx - IW'(2 * D) : r_idx;
    assign w_ge1     = w_i1 >= IW'(D);
    assign w_rr      = w_ge1 ? w_i1 - IW'(D) : w_i1;
    assign w_rd_addr = w_ge1 ? AW'(D) - AW'(w_rr) : AW'(w_rr);

    // Table memory: written during build, read in the cycle after accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_write) r_table[r_k] <= w_entry;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_idx <= w_idx_prod[32 +: IW];
        if (i_cmd.mul) begin
            r_tab_q <= r_table[w_rd_addr];
            r_sneg  <= w_ge2;
        end
        if (i_cmd.freq) begin
            r_sample <= r_sneg ? -signed'({1'b0, r_tab_q}) : signed'({1'b0, r_tab_q});
        end
    end

    // ---------------- frequency ----------------
    logic signed [31:0] r_mod;
    logic signed [63:0] r_prod;
    logic signed [48:0] w_fsum;
    logic signed [31:0] r_freq;

    assign w_fsum = 49'(r_prod >>> 16) + 49'(r_offset);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_mod <= i_mod_value;
        if (i_cmd.mul) r_prod <= r_mod * r_scale;
        if (i_cmd.freq) begin
            if (w_fsum > F_MAX) begin
                r_freq <= 32'sh7FFF_FFFF;
            end else if (w_fsum < F_MIN) begin
                r_freq <= 32'sh8000_0000;
            end else begin
                r_freq <= w_fsum[31:0];
            end
        end
    end

    // ---------------- step divider, two quotient bits per cycle ----------------
    logic [31:0]     w_mag;
    logic [EW-1:0]   r_quo;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_dr;
    logic            r_fneg;
    logic [CNTW-1:0] r_cnt;
    logic [RW:0]     w_t1;
    logic [RW:0]     w_t2;
    logic            w_b1;
    logic            w_b2;
    logic [RW-1:0]   w_rm1;
    logic [RW-1:0]   w_rm2;
    logic [EW-1:0]   w_q1;

    assign w_mag = r_freq[31] ? 32'(-r_freq) : 32'(r_freq);
    assign w_t1  = {r_rem, r_quo[EW-1]};
    assign w_b1  = w_t1 >= {1'b0, r_dr};
    assign w_rm1 = w_b1 ? RW'(w_t1 - {1'b0, r_dr}) : w_t1[RW-1:0];
    assign w_q1  = {r_quo[EW-2:0], w_b1};
    assign w_t2  = {w_rm1, w_q1[EW-1]};
    assign w_b2  = w_t2 >= {1'b0, r_dr};
    assign w_rm2 = w_b2 ? RW'(w_t2 - {1'b0, r_dr}) : w_t2[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo  <= EW'(w_mag) << (PHASE_BITS - 16);
            r_rem  <= '0;
            r_dr   <= (r_rate == '0) ? RW'(1) : r_rate;
            r_fneg <= r_freq[31];
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {w_q1[EW-2:0], w_b2};
            r_rem <= w_rm2;
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // Move the phase by the quotient, wrapping both ways
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.phase_upd) begin
            r_phase <= r_fneg ? r_phase - r_quo[PHASE_BITS-1:0]
                              : r_phase + r_quo[PHASE_BITS-1:0];
        end
    end

    // ---------------- output register ----------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) o_sample <= r_sample;
    end

    assign o_valid = r_out_valid;

    // ---------------- status ----------------
    assign o_sts.cordic_last = r_it == snco_pkg::IT_W'(snco_pkg::CORDIC_ITERS - 1);
    assign o_sts.build_last  = r_k == AW'(D);
    assign o_sts.build_done  = r_built;
    assign o_sts.div_last    = r_cnt == CNTW'(NSTEP - 1);
    assign o_sts.out_free    = !r_out_valid || i_ready;

    // Partial remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_dr))
        else $error("divider remainder out of range");

    // Table reads stay inside the quarter wave
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> (w_rd_addr <= AW'(D)))
        else $error("sine table address out of range");

    // A new item never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_ready))
        else $error("output overwritten");

endmodule

`default_nettype wire
